### hdl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Types, codes and constants shared by the chunk pool allocator modules.
// ----------------------------------------------------------------------------
package cpa_pkg;

	// default sizing of the pool
	localparam int unsigned DEF_MAX_CHUNKS  = 256;
	localparam int unsigned DEF_CHUNK_ALIGN = 8;

	// field and register widths
	localparam int unsigned ADDR_W    = 16;
	localparam int unsigned CFG_W     = 17;
	localparam int unsigned CFG_IDX_W = 1;
	// divider width: covers chunk_bytes plus alignment slack
	localparam int unsigned DIV_W     = 18;

	// register reset values
	localparam logic [CFG_W-1:0] BUF_LEN_RST     = 17'h10000;
	localparam logic [CFG_W-1:0] CHUNK_BYTES_RST = 17'h00040;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES   = 1'b1;

	typedef enum logic [1:0] {
		REQ_ALLOC    = 2'd0,
		REQ_FREE     = 2'd1,
		REQ_FREE_ALL = 2'd2,
		REQ_NOP      = 2'd3
	} req_code_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_EMPTY  = 2'd1,
		STAT_BOUNDS = 2'd2,
		STAT_NULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_READ,
		S_FILL,
		S_RES
	} state_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [ADDR_W-1:0] address;
		logic              null_pointer;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] chunk_address;
	} rsp_t;

endpackage

### hdl/cpa_div.sv
// ----------------------------------------------------------------------------
// cpa_div
// Restoring unsigned divider, one quotient bit per cycle. done pulses for one
// cycle when the quotient is valid; the quotient holds until the next start.
// ----------------------------------------------------------------------------
module cpa_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cpa_pkg::DIV_W-1:0] dividend,
	input  logic [cpa_pkg::DIV_W-1:0] divisor,
	output logic                       done,
	output logic [cpa_pkg::DIV_W-1:0] quotient
);
	import cpa_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_W'(shifted - {1'b0, dsr_q}) : shifted[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### hdl/chunk_pool_free_list_allocator.sv
// ----------------------------------------------------------------------------
// chunk_pool_free_list_allocator
// Fixed-size chunk pool with a last-in-first-out free list held in RAM.
// ----------------------------------------------------------------------------
// Usage: write buffer_length (index 0) and chunk_bytes (index 1) on the cfg
// port while the block is idle, then issue a free-all to build the list.
// Requests enter on req (valid/stall) one at a time; every request returns
// exactly one word on rsp (valid/stall) holding a status and, for a
// successful allocate, the chunk's byte offset.
// Work per request, accept to result offered:
//   allocate, no-op, rejected free : at most one link RAM read
//   free                           : offset / size divider, then one push
//   free-all                       : length / size divider, then the list
//                                    rebuild, one link written per cycle
// CHUNK_ALIGN is a power of two; the rounded chunk size is taken on each
// chunk_bytes write.
// req_stall is high from acceptance until the result is in the output
// register; the next request is taken while that result waits. A stalled
// rsp holds its word, and a finished request waits for the output to drain.
// Reset leaves the list empty and the chunk count at zero; the link RAM is
// not cleared.
// ----------------------------------------------------------------------------
module chunk_pool_free_list_allocator #(
	parameter int unsigned MAX_CHUNKS  = cpa_pkg::DEF_MAX_CHUNKS,
	parameter int unsigned CHUNK_ALIGN = cpa_pkg::DEF_CHUNK_ALIGN
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cpa_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  cpa_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output cpa_pkg::rsp_t                  rsp
);
	import cpa_pkg::*;

	localparam int unsigned AW    = $clog2(MAX_CHUNKS);
	localparam int unsigned IDX_W = $clog2(MAX_CHUNKS + 1);
	localparam int unsigned OP_W  = AW + DIV_W;
	localparam logic [IDX_W-1:0] EMPTY = IDX_W'(MAX_CHUNKS);

	state_t state_q, state_d;

	logic [CFG_W-1:0] bl_q;
	logic [DIV_W-1:0] size_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] total_q;
	logic [AW-1:0]    fill_q;
	req_t             req_q;
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic [IDX_W-1:0] links [MAX_CHUNKS];
	logic [IDX_W-1:0] rd_link_s1;
	logic [AW-1:0]    rd_addr;

	logic             req_acc;
	logic             rsp_free;
	logic             head_empty;
	logic             addr_oob;
	logic             idx_oob;
	logic             fill_last;
	logic             is_free_all;
	logic [IDX_W-1:0] sat_count;
	logic [OP_W-1:0]  off_prod;

	logic             div_start;
	logic             div_done;
	logic [DIV_W-1:0] div_dividend;
	logic [DIV_W-1:0] div_divisor;
	logic [DIV_W-1:0] div_quo;

	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [IDX_W-1:0] mem_wd;
	logic             head_we;
	logic [IDX_W-1:0] head_d;
	logic             total_we;
	logic             fill_clr;
	logic             fill_inc;
	logic             res_we;
	rsp_t             res_d;

	// round up to the alignment by mask; zero counts as one alignment unit
	function automatic logic [DIV_W-1:0] round_size(input logic [CFG_W-1:0] b);
		logic [DIV_W-1:0] s;
		s = (DIV_W'(b) + DIV_W'(CHUNK_ALIGN - 1)) & ~DIV_W'(CHUNK_ALIGN - 1);
		return (s == '0) ? DIV_W'(CHUNK_ALIGN) : s;
	endfunction

	assign req_stall   = (state_q != S_IDLE);
	assign req_acc     = req_valid && !req_stall;
	assign rsp_free    = !rsp_valid_q || !rsp_stall;
	assign head_empty  = (head_q == EMPTY);
	assign addr_oob    = {1'b0, req_q.address} >= bl_q;
	assign idx_oob     = div_quo >= DIV_W'(total_q);
	assign fill_last   = (IDX_W'(fill_q) + IDX_W'(1)) == total_q;
	assign is_free_all = (req_q.req_type == REQ_FREE_ALL);
	assign sat_count   = (div_quo > DIV_W'(MAX_CHUNKS)) ? EMPTY : div_quo[IDX_W-1:0];
	assign off_prod    = OP_W'(head_q[AW-1:0]) * OP_W'(size_q);
	assign rd_addr     = head_empty ? '0 : head_q[AW-1:0];

	// offset or buffer length over chunk size
	assign div_dividend = is_free_all ? DIV_W'(bl_q) : DIV_W'(req_q.address);
	assign div_divisor  = size_q;

	cpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_acc) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (req_code_t'(req_q.req_type))
					REQ_ALLOC:    state_d = head_empty ? S_RES : S_READ;
					REQ_FREE:     state_d = (req_q.null_pointer || addr_oob) ? S_RES : S_DIV;
					REQ_FREE_ALL: state_d = S_DIV;
					default:      state_d = S_RES;
				endcase
			end
			S_DIV: begin
				if (div_done) state_d = (is_free_all && sat_count != '0) ? S_FILL : S_RES;
			end
			S_FILL: begin
				if (fill_last) state_d = S_RES;
			end
			S_READ: state_d = S_RES;
			S_RES: begin
				if (rsp_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		div_start           = 1'b0;
		mem_we              = 1'b0;
		mem_wa              = '0;
		mem_wd              = head_q;
		head_we             = 1'b0;
		head_d              = head_q;
		total_we            = 1'b0;
		fill_clr            = 1'b0;
		fill_inc            = 1'b0;
		res_we              = 1'b0;
		res_d.status        = STAT_OK;
		res_d.chunk_address = '0;
		case (state_q)
			S_EXEC: begin
				case (req_code_t'(req_q.req_type))
					REQ_ALLOC: begin
						if (head_empty) begin
							res_we       = 1'b1;
							res_d.status = STAT_EMPTY;
						end
					end
					REQ_FREE: begin
						if (req_q.null_pointer) begin
							res_we       = 1'b1;
							res_d.status = STAT_NULL;
						end else if (addr_oob) begin
							res_we       = 1'b1;
							res_d.status = STAT_BOUNDS;
						end else begin
							div_start = 1'b1;
						end
					end
					REQ_FREE_ALL: div_start = 1'b1;
					default:      res_we = 1'b1;
				endcase
			end
			S_DIV: begin
				if (div_done) begin
					res_we = 1'b1;
					if (is_free_all) begin
						total_we = 1'b1;
						head_we  = 1'b1;
						head_d   = EMPTY;
						fill_clr = 1'b1;
					end else if (idx_oob) begin
						res_d.status = STAT_BOUNDS;
					end else begin
						mem_we  = 1'b1;
						mem_wa  = div_quo[AW-1:0];
						head_we = 1'b1;
						head_d  = div_quo[IDX_W-1:0];
					end
				end
			end
			S_FILL: begin
				// push chunk fill_q, as a free would
				mem_we   = 1'b1;
				mem_wa   = fill_q;
				head_we  = 1'b1;
				head_d   = IDX_W'(fill_q);
				fill_inc = 1'b1;
			end
			S_READ: begin
				head_we             = 1'b1;
				head_d              = rd_link_s1;
				res_we              = 1'b1;
				res_d.chunk_address = off_prod[ADDR_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bl_q        <= BUF_LEN_RST;
			size_q      <= round_size(CHUNK_BYTES_RST);
			head_q      <= EMPTY;
			total_q     <= '0;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_BUFFER_LENGTH: bl_q <= cfg_data;
					CFG_CHUNK_BYTES:   size_q <= round_size(cfg_data);
					default: ;
				endcase
			end
			if (head_we) head_q <= head_d;
			if (total_we) total_q <= sat_count;
			if (fill_clr) fill_q <= '0;
			else if (fill_inc) fill_q <= fill_q + AW'(1);
			if (state_q == S_RES && rsp_free) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_acc) req_q <= req;
		if (res_we) res_q <= res_d;
		if (state_q == S_RES && rsp_free) rsp_q <= res_q;
	end

	// link RAM, read at the list head every cycle
	always_ff @(posedge clk) begin
		if (mem_we) links[mem_wa] <= mem_wd;
		rd_link_s1 <= links[rd_addr];
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
